// File: hdl/fsp_pkg.sv
`default_nettype none
package fsp_pkg;
  localparam int unsigned SECTIONS = 8;
  localparam int unsigned SLOTS = SECTIONS + 1;
  localparam int unsigned HISTORY_DEPTH = 256;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned HIDX_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned HCNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned RATE_W = 38;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP = 3'd1;
  localparam logic [2:0] OP_SET = 3'd2;
  localparam logic [2:0] OP_FSTART = 3'd3;
  localparam logic [2:0] OP_FEND = 3'd4;
  localparam logic [2:0] OP_STATUS = 3'd5;
  localparam logic [2:0] OP_HIST = 3'd6;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_HIST = 2'd2;

  localparam logic [0:0] REG_KHZ = 1'd0;
  localparam logic [0:0] REG_GOAL = 1'd1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  category;
    logic [63:0] timestamp;
    logic [31:0] set_ticks;
    logic [7:0]  age;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [31:0]       frame_ticks;
    logic [RATE_W-1:0] fps_last;
    logic [RATE_W-1:0] fps_min;
    logic [RATE_W-1:0] fps_max;
    logic [RATE_W-1:0] fps_avg;
    logic [31:0]       run_ticks;
    logic [31:0]       wait_ticks;
    logic [31:0]       history_ticks;
    logic [8:0]        frames_held;
  } out_item_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [63:0] b);
    logic [32:0] s;
    logic [31:0] bc;
    bc = (b[63:32] != '0) ? 32'hFFFF_FFFF : b[31:0];
    s = {1'b0, a} + {1'b0, bc};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage
`default_nettype wire

// File: hdl/fsp_if.sv
`default_nettype none
interface fsp_in_if;
  logic valid;
  logic ready;
  fsp_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fsp_out_if;
  logic valid;
  logic ready;
  fsp_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fsp_cfg_if;
  logic valid;
  logic ready;
  fsp_pkg::cfg_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/fsp_ram.sv
`default_nettype none
module fsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  // write one entry, read one registered
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: hdl/fsp_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module fsp_div (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire [63:0]  num_i,
  input  wire [63:0]  den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [64:0] trial;

  assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};
  assign quo_o = quo_q;

  // shift in one bit and subtract when it fits
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end else begin
      done_o = (cnt_q == 7'd0) && !busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 7'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end
endmodule
`default_nettype wire

// File: hdl/frame_section_profiler.sv
`default_nettype none
// Channel | Dir | Handshake   | Payload
// in      | in  | valid/ready | operation, category, timestamp, set_ticks, age
// out     | out | valid/ready | kind, frame_ticks, fps_*, elapsed/wait/history, frames_held
// cfg     | in  | valid/ready | index (0 counter_khz, 1 goal_frame_ticks), data
// Start, stop, set and the unused operation go through EMIT back to idle; status and
// history reads go through RD, RD2 and OUT. Frame end runs an 8-step section sweep,
// then waits twice on the shared restoring divider (rate, then running average).
// Frame start clears the sections, first running the frame-end steps if a frame is open.
// Reset clears sections, counters and rates (min to all ones); history RAM needs no clearing.
// The input is not ready while an item is worked on or its result waits to be taken.
module frame_section_profiler (
  input wire clk_i,
  input wire rst_ni,
  fsp_in_if.sink    in_ch,
  fsp_out_if.source out_ch,
  fsp_cfg_if.sink   cfg_ch
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUM = 4'd1;
  localparam logic [3:0] S_STORE = 4'd2;
  localparam logic [3:0] S_RDIV = 4'd3;
  localparam logic [3:0] S_RWAIT = 4'd4;
  localparam logic [3:0] S_AMUL = 4'd5;
  localparam logic [3:0] S_ADIV = 4'd6;
  localparam logic [3:0] S_AWAIT = 4'd7;
  localparam logic [3:0] S_RD = 4'd8;
  localparam logic [3:0] S_RD2 = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;
  localparam logic [3:0] S_CLR = 4'd12;

  logic [3:0] st_q, st_d;
  logic [19:0] khz_q;
  logic [31:0] goal_q;
  logic [63:0] start_q [fsp_pkg::SLOTS];
  logic [fsp_pkg::SLOTS-1:0] run_q;
  logic [31:0] acc_q [fsp_pkg::SLOTS];
  logic [fsp_pkg::HIDX_W-1:0] newest_q;
  logic [fsp_pkg::HCNT_W-1:0] held_q;
  logic [fsp_pkg::RATE_W-1:0] rmin_q, rmax_q, ravg_q, rlast_q;
  fsp_pkg::in_item_t item_q;
  fsp_pkg::out_item_t out_q;
  logic [fsp_pkg::SLOT_W-1:0] idx_q;
  logic [31:0] sum_q, total_q, elapsed_q;
  logic [1:0] kind_q;
  logic fstart_q;
  logic [63:0] amul_q;

  logic tot_we;
  logic [fsp_pkg::HIDX_W-1:0] tot_raddr;
  logic [31:0] tot_rdata;

  logic div_start, div_done;
  logic [63:0] div_num, div_den, div_quo;

  logic [fsp_pkg::SLOT_W-1:0] cat_s;
  logic cat_ok;
  logic [63:0] span;
  logic [31:0] elap_now;
  logic [fsp_pkg::HIDX_W-1:0] next_idx;

  assign cat_ok = item_q.category <= 4'(fsp_pkg::SECTIONS);
  assign cat_s = item_q.category[fsp_pkg::SLOT_W-1:0];
  assign span = item_q.timestamp - start_q[fsp_pkg::SECTIONS];
  assign elap_now = !run_q[fsp_pkg::SECTIONS] ? acc_q[fsp_pkg::SECTIONS]
                  : (span[63:32] != '0 ? 32'hFFFF_FFFF : span[31:0]);
  assign next_idx = (held_q != '0) ? newest_q + 1'b1 : newest_q;

  assign in_ch.ready = (st_q == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (st_q == S_OUT);
  assign out_ch.data = out_q;

  assign tot_we = (st_q == S_STORE);
  assign tot_raddr = (st_q == S_RD) ? newest_q - item_q.age : newest_q;
  assign div_start = (st_q == S_RDIV) || (st_q == S_ADIV);
  assign div_num = (st_q == S_RDIV) ? 64'(38'(khz_q) * 38'd256000) : amul_q + 64'(rlast_q);
  assign div_den = (st_q == S_RDIV) ? 64'(total_q) : 64'(held_q);

  fsp_ram #(.WIDTH(32), .DEPTH(fsp_pkg::HISTORY_DEPTH)) u_tot (
    .clk_i(clk_i), .we_i(tot_we), .waddr_i(newest_q), .wdata_i(total_q),
    .raddr_i(tot_raddr), .rdata_o(tot_rdata)
  );

  fsp_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .quo_o(div_quo)
  );

  // sequence one item
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_ch.valid) st_d = S_EMIT;
      S_EMIT: begin
        case (item_q.operation)
          fsp_pkg::OP_FEND: st_d = S_SUM;
          fsp_pkg::OP_FSTART: st_d = run_q[fsp_pkg::SECTIONS] ? S_SUM : S_CLR;
          fsp_pkg::OP_STATUS, fsp_pkg::OP_HIST: st_d = S_RD;
          default: st_d = S_IDLE;
        endcase
      end
      S_SUM: if (32'(idx_q) == fsp_pkg::SECTIONS - 1) st_d = S_STORE;
      S_STORE: st_d = S_RDIV;
      S_RDIV: st_d = S_RWAIT;
      S_RWAIT: if (div_done) st_d = S_AMUL;
      S_AMUL: st_d = S_ADIV;
      S_ADIV: st_d = S_AWAIT;
      S_AWAIT: if (div_done) st_d = S_RD;
      S_RD: st_d = S_RD2;
      S_RD2: st_d = S_OUT;
      S_OUT: if (out_ch.ready) st_d = fstart_q ? S_CLR : S_IDLE;
      S_CLR: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      khz_q <= 20'd1000;
      goal_q <= 32'd16667;
      run_q <= '0;
      for (int i = 0; i < fsp_pkg::SLOTS; i++) begin
        start_q[i] <= '0;
        acc_q[i] <= '0;
      end
      newest_q <= '0;
      held_q <= '0;
      rmin_q <= '1;
      rmax_q <= '0;
      ravg_q <= '0;
      rlast_q <= '0;
      fstart_q <= 1'b0;
      idx_q <= '0;
      sum_q <= '0;
      elapsed_q <= '0;
      kind_q <= fsp_pkg::KIND_FRAME;
    end else begin
      st_q <= st_d;
      if (cfg_ch.valid) begin
        if (cfg_ch.data.index == fsp_pkg::REG_KHZ) khz_q <= cfg_ch.data.data[19:0];
        else goal_q <= cfg_ch.data.data;
      end
      case (st_q)
        S_EMIT: begin
          idx_q <= '0;
          sum_q <= '0;
          fstart_q <= (item_q.operation == fsp_pkg::OP_FSTART);
          if (cat_ok) begin
            case (item_q.operation)
              fsp_pkg::OP_START: begin
                start_q[cat_s] <= item_q.timestamp;
                run_q[cat_s] <= 1'b1;
              end
              fsp_pkg::OP_STOP: if (run_q[cat_s]) begin
                acc_q[cat_s] <= fsp_pkg::sat_add32(acc_q[cat_s],
                                                   item_q.timestamp - start_q[cat_s]);
                run_q[cat_s] <= 1'b0;
              end
              fsp_pkg::OP_SET: begin
                run_q[cat_s] <= 1'b0;
                acc_q[cat_s] <= item_q.set_ticks;
              end
              default: ;
            endcase
          end
          if ((item_q.operation == fsp_pkg::OP_FEND ||
               item_q.operation == fsp_pkg::OP_FSTART) && run_q[fsp_pkg::SECTIONS]) begin
            acc_q[fsp_pkg::SECTIONS] <= fsp_pkg::sat_add32(acc_q[fsp_pkg::SECTIONS], span);
            run_q[fsp_pkg::SECTIONS] <= 1'b0;
          end
          elapsed_q <= elap_now;
          kind_q <= (item_q.operation == fsp_pkg::OP_STATUS) ? fsp_pkg::KIND_STATUS
                  : (item_q.operation == fsp_pkg::OP_HIST) ? fsp_pkg::KIND_HIST
                  : fsp_pkg::KIND_FRAME;
        end
        // accumulate one section per cycle
        S_SUM: begin
          sum_q <= fsp_pkg::sat_add32(sum_q, 64'(acc_q[idx_q]));
          idx_q <= idx_q + 1'b1;
        end
        S_STORE: ;
        default: ;
      endcase
      if (st_q == S_SUM && st_d == S_STORE) begin
        newest_q <= next_idx;
        if (held_q != fsp_pkg::HCNT_W'(fsp_pkg::HISTORY_DEPTH)) held_q <= held_q + 1'b1;
        elapsed_q <= acc_q[fsp_pkg::SECTIONS];
      end
      if (st_q == S_RWAIT && div_done) begin
        rlast_q <= div_quo[fsp_pkg::RATE_W-1:0];
        if (newest_q == '0) begin
          rmin_q <= div_quo[fsp_pkg::RATE_W-1:0];
          rmax_q <= div_quo[fsp_pkg::RATE_W-1:0];
        end else begin
          if (div_quo[fsp_pkg::RATE_W-1:0] < rmin_q) rmin_q <= div_quo[fsp_pkg::RATE_W-1:0];
          if (div_quo[fsp_pkg::RATE_W-1:0] > rmax_q) rmax_q <= div_quo[fsp_pkg::RATE_W-1:0];
        end
      end
      if (st_q == S_AWAIT && div_done) ravg_q <= div_quo[fsp_pkg::RATE_W-1:0];
      // clear the sections and restart the frame timer
      if (st_q == S_CLR) begin
        run_q <= {1'b1, {fsp_pkg::SECTIONS{1'b0}}};
        for (int i = 0; i < fsp_pkg::SECTIONS; i++) begin
          start_q[i] <= '0;
          acc_q[i] <= '0;
        end
        start_q[fsp_pkg::SECTIONS] <= item_q.timestamp;
        acc_q[fsp_pkg::SECTIONS] <= '0;
        fstart_q <= 1'b0;
      end
    end
  end

  // payload and result assembly
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && st_q == S_IDLE) item_q <= in_ch.data;
    if (st_q == S_SUM && st_d == S_STORE) begin
      total_q <= (fsp_pkg::sat_add32(sum_q, 64'(acc_q[idx_q])) != '0)
               ? fsp_pkg::sat_add32(sum_q, 64'(acc_q[idx_q]))
               : (khz_q != '0 ? 32'(khz_q) : 32'd1);
    end
    if (st_q == S_AMUL) amul_q <= 64'(ravg_q) * 64'(held_q - 1'b1);
    // newest total was addressed the cycle before
    if (st_q == S_RD) out_q.frame_ticks <= (held_q != '0) ? tot_rdata : 32'd0;
    if (st_q == S_RD2) begin
      out_q.kind <= kind_q;
      out_q.fps_last <= rlast_q;
      out_q.fps_min <= rmin_q;
      out_q.fps_max <= rmax_q;
      out_q.fps_avg <= ravg_q;
      out_q.run_ticks <= elapsed_q;
      out_q.wait_ticks <= (goal_q > elapsed_q) ? goal_q - elapsed_q : 32'd0;
      out_q.frames_held <= 9'(held_q);
      out_q.history_ticks <= (kind_q == fsp_pkg::KIND_HIST &&
                 fsp_pkg::HCNT_W'(item_q.age) < held_q) ? tot_rdata : 32'd0;
    end
  end
endmodule
`default_nettype wire
